// ===== src/kcl_pkg.sv =====
// Shared types, field widths and codes for the keypad code lock.
package kcl_pkg;

    // Number of digits in a code.
    localparam int CODE_LENGTH = 4;

    localparam int DIGIT_W = 4;
    localparam int MODE_W  = 2;
    localparam int ATT_W   = 3;
    localparam int CNT_W   = 3;
    localparam int TICK_W  = 16;
    localparam int EV_W    = 3;
    localparam int IDX_W   = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_BITS   = MODE_W + 2 + ATT_W + CNT_W + TICK_W + EV_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_ATTEMPTS  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LOCKOUT_TICKS = 1'd1;

    localparam logic [ATT_W-1:0]  MAX_ATTEMPTS_RST  = 3'd3;
    localparam logic [TICK_W-1:0] LOCKOUT_TICKS_RST = 16'd61;
    localparam logic [TICK_W-1:0] TICK_MAX          = {TICK_W{1'b1}};
    localparam logic [DIGIT_W-1:0] DIGIT_MAX        = 4'd9;

    // Item kinds carried on the input tuser bit.
    localparam logic CMD_DIGIT = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [MODE_W-1:0] MODE_SET      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOCKED   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UNLOCKED = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DISABLED = 2'd3;

    localparam logic [EV_W-1:0] EV_NONE     = 3'd0;
    localparam logic [EV_W-1:0] EV_DIGIT    = 3'd1;
    localparam logic [EV_W-1:0] EV_CODE_SET = 3'd2;
    localparam logic [EV_W-1:0] EV_GRANTED  = 3'd3;
    localparam logic [EV_W-1:0] EV_DENIED   = 3'd4;
    localparam logic [EV_W-1:0] EV_DISABLED = 3'd5;
    localparam logic [EV_W-1:0] EV_ENABLED  = 3'd6;

    typedef struct packed {
        logic               cmd;
        logic [DIGIT_W-1:0] digit;
    } item_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              red_led;
        logic              green_led;
        logic [ATT_W-1:0]  attempts_left;
        logic [CNT_W-1:0]  digits_entered;
        logic [TICK_W-1:0] lockout_remaining;
        logic [EV_W-1:0]   event_res;
    } result_t;

endpackage

// ===== src/kcl_in_stage.sv =====
// Input register stage: holds one accepted item until the core consumes it.
module kcl_in_stage
    import kcl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  advance,
    output logic  hold_valid,
    output item_t hold_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;

endmodule

// ===== src/kcl_core.sv =====
// Lock state, configuration registers and the single-pass next-state logic.
module kcl_core
    import kcl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  advance,
    input  item_t                 item,
    output result_t               result
);

    logic [ATT_W-1:0]  max_attempts_reg;
    logic [TICK_W-1:0] lockout_ticks_reg;

    logic [MODE_W-1:0]  mode_reg,     mode_next;
    logic [CNT_W-1:0]   count_reg,    count_next;
    logic [ATT_W-1:0]   attempts_reg, attempts_next;
    logic [TICK_W-1:0]  elapsed_reg,  elapsed_next;
    logic [DIGIT_W-1:0] code_reg  [CODE_LENGTH];
    logic [DIGIT_W-1:0] code_next [CODE_LENGTH];
    logic [DIGIT_W-1:0] entry_reg [CODE_LENGTH];
    logic [DIGIT_W-1:0] entry_next[CODE_LENGTH];

    logic [EV_W-1:0]    ev;
    logic [CNT_W:0]     count_plus;
    logic               last_digit;
    logic [IDX_W-1:0]   idx;
    logic [TICK_W-1:0]  elapsed_inc;
    logic               match;
    logic [TICK_W-1:0]  remaining;

    assign count_plus  = {1'b0, count_reg} + 1'b1;
    assign last_digit  = (count_plus >= (CNT_W + 1)'(CODE_LENGTH));
    assign idx         = count_reg[IDX_W-1:0];
    assign elapsed_inc = (elapsed_reg < TICK_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;

    // The digit just pressed takes the place of the stored entry at the current index.
    always_comb
    begin
        match = 1'b1;
        for (int i = 0; i < CODE_LENGTH; i++)
        begin
            if (((IDX_W'(i) == idx) ? item.digit : entry_reg[i]) != code_reg[i])
            begin
                match = 1'b0;
            end
        end
    end

    always_comb
    begin
        mode_next     = mode_reg;
        count_next    = count_reg;
        attempts_next = attempts_reg;
        elapsed_next  = elapsed_reg;
        code_next     = code_reg;
        entry_next    = entry_reg;
        ev            = EV_NONE;
        if (item.cmd == CMD_TICK)
        begin
            if (mode_reg == MODE_DISABLED)
            begin
                if (elapsed_inc >= lockout_ticks_reg)
                begin
                    mode_next     = MODE_LOCKED;
                    attempts_next = max_attempts_reg;
                    count_next    = '0;
                    elapsed_next  = '0;
                    ev            = EV_ENABLED;
                end
                else
                begin
                    elapsed_next = elapsed_inc;
                end
            end
        end
        else if (item.digit <= DIGIT_MAX && mode_reg != MODE_DISABLED)
        begin
            if (mode_reg == MODE_SET || mode_reg == MODE_UNLOCKED)
            begin
                code_next[idx] = item.digit;
                if (last_digit)
                begin
                    count_next = '0;
                    mode_next  = MODE_LOCKED;
                    ev         = EV_CODE_SET;
                end
                else
                begin
                    count_next = count_plus[CNT_W-1:0];
                    ev         = EV_DIGIT;
                end
            end
            else
            begin
                entry_next[idx] = item.digit;
                if (!last_digit)
                begin
                    count_next = count_plus[CNT_W-1:0];
                    ev         = EV_DIGIT;
                end
                else
                begin
                    count_next = '0;
                    if (match)
                    begin
                        mode_next = MODE_UNLOCKED;
                        ev        = EV_GRANTED;
                    end
                    else if (attempts_reg <= ATT_W'(1))
                    begin
                        attempts_next = '0;
                        elapsed_next  = '0;
                        mode_next     = MODE_DISABLED;
                        ev            = EV_DISABLED;
                    end
                    else
                    begin
                        attempts_next = attempts_reg - 1'b1;
                        ev            = EV_DENIED;
                    end
                end
            end
        end
    end

    assign remaining = (mode_next == MODE_DISABLED && lockout_ticks_reg > elapsed_next)
                       ? lockout_ticks_reg - elapsed_next : '0;

    always_comb
    begin
        result.mode              = mode_next;
        result.red_led           = (mode_next == MODE_LOCKED) || (mode_next == MODE_DISABLED);
        result.green_led         = (mode_next == MODE_UNLOCKED);
        result.attempts_left     = attempts_next;
        result.digits_entered    = count_next;
        result.lockout_remaining = remaining;
        result.event_res         = ev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_attempts_reg  <= MAX_ATTEMPTS_RST;
            lockout_ticks_reg <= LOCKOUT_TICKS_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_MAX_ATTEMPTS:  max_attempts_reg  <= cfg_wdata[ATT_W-1:0];
                REG_LOCKOUT_TICKS: lockout_ticks_reg <= cfg_wdata[TICK_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_SET;
            count_reg    <= '0;
            attempts_reg <= MAX_ATTEMPTS_RST;
            elapsed_reg  <= '0;
        end
        else if (advance)
        begin
            mode_reg     <= mode_next;
            count_reg    <= count_next;
            attempts_reg <= attempts_next;
            elapsed_reg  <= elapsed_next;
        end
    end

    // Digit stores hold no meaning until written, so they carry no reset.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            code_reg  <= code_next;
            entry_reg <= entry_next;
        end
    end

endmodule

// ===== src/kcl_out_stage.sv =====
// Result register stage: holds one result item until the downstream side takes it.
module kcl_out_stage
    import kcl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    output logic    out_free,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic    valid_reg;
    result_t result_reg;

    assign out_free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

// ===== src/keypad_code_lock.sv =====
// Top level of the keypad code lock: input register, lock core and result register.
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tuser = cmd, tdata = digit
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata = packed result fields
//  cfg       in         cfg_wr_en (no wait)           cfg_addr, cfg_wdata
//
// An accepted item is held in the input register until the core takes it, and its result
// is then registered in the result register, from which it is offered on m_axis.
// One item is taken per cycle while m_axis does not stall; the core updates its state in one pass.
// A result held on m_axis stalls the input register, which then stalls s_axis.
// Reset returns the mode, counters and configuration to their reset values;
// the stored code is unset.
module keypad_code_lock
    import kcl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [3:0] digit
    input  logic                  s_axis_tuser,  // [0] cmd
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [1:0] mode, [2] red_led, [3] green_led, [6:4] attempts_left,
    // [9:7] digits_entered, [25:10] lockout_remaining, [28:26] event_res
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    item_t     in_item;
    item_t     hold_item;
    logic      hold_valid;
    logic      out_free;
    logic      advance;
    result_t   result;
    result_t   out_result;

    assign in_item.cmd   = s_axis_tuser;
    assign in_item.digit = s_axis_tdata[DIGIT_W-1:0];
    assign advance       = hold_valid && out_free;

    kcl_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_item  (hold_item)
    );

    kcl_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .item      (hold_item),
        .result    (result)
    );

    kcl_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .result     (result),
        .out_free   (out_free),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (out_result)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}},
                           out_result.event_res,
                           out_result.lockout_remaining,
                           out_result.digits_entered,
                           out_result.attempts_left,
                           out_result.green_led,
                           out_result.red_led,
                           out_result.mode};

endmodule

// ===== src/kcl_checker.sv =====
// Port-level checks for the keypad code lock, bound to the top level.
module kcl_checker
    import kcl_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [MODE_W-1:0] mode;
    logic              red;
    logic              green;
    logic [ATT_W-1:0]  att;
    logic [TICK_W-1:0] rem;
    logic [EV_W-1:0]   ev;

    assign mode  = m_axis_tdata[MODE_W-1:0];
    assign red   = m_axis_tdata[MODE_W];
    assign green = m_axis_tdata[MODE_W+1];
    assign att   = m_axis_tdata[MODE_W+2 +: ATT_W];
    assign rem   = m_axis_tdata[MODE_W+2+ATT_W+CNT_W +: TICK_W];
    assign ev    = m_axis_tdata[MODE_W+2+ATT_W+CNT_W+TICK_W +: EV_W];

    // The lamps follow the mode of the same result.
    a_leds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (red == (mode == MODE_LOCKED || mode == MODE_DISABLED)) &&
            (green == (mode == MODE_UNLOCKED)))
        else $error("lamp outputs disagree with mode");

    // A lockout count is only shown while disabled.
    a_rem_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && rem != '0) |-> (mode == MODE_DISABLED))
        else $error("lockout count outside disabled mode");

    // Entering the lockout leaves no attempts.
    a_disable: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && ev == EV_DISABLED) |-> (mode == MODE_DISABLED && att == '0))
        else $error("disable event with wrong mode or attempts");

    // Grant opens the lock; code set and re-enable leave it locked.
    a_events: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (ev != EV_GRANTED || mode == MODE_UNLOCKED) &&
            (ev != EV_CODE_SET || mode == MODE_LOCKED) &&
            (ev != EV_ENABLED || mode == MODE_LOCKED))
        else $error("event does not match resulting mode");

    // A result held back by the receiver stays in place.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind keypad_code_lock kcl_checker u_kcl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
